// ===== design/substr_pkg.sv =====
// Shared types, register indexes and the letter-folding helper for the
// substring search block. No dependencies.
`default_nettype none

package substr_pkg;

    // Needle storage in bytes (four 64-bit configuration words)
    localparam int unsigned NEEDLE_STORE = 32;

    // Configuration register indexes
    localparam logic [2:0] REG_NEEDLE_LENGTH = 3'd0;
    localparam logic [2:0] REG_IGNORE_CASE   = 3'd1;
    localparam logic [2:0] REG_NEEDLE_WORD0  = 3'd2;
    localparam logic [2:0] REG_NEEDLE_WORD1  = 3'd3;
    localparam logic [2:0] REG_NEEDLE_WORD2  = 3'd4;
    localparam logic [2:0] REG_NEEDLE_WORD3  = 3'd5;

    // Control shared by every window cell
    typedef struct packed {
        logic shift;
        logic ignore_case;
    } t_cell_ctl;

    // One result item
    typedef struct packed {
        logic        found;
        logic [15:0] match_index;
    } t_result;

    // Fold a..z to A..Z when case is ignored
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && (c >= 8'h61) && (c <= 8'h7A)) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/substr_cell.sv =====
// One window cell: holds one haystack byte, passes it on to the next cell
// on a shift and compares the incoming byte with its needle byte.
// Depends on substr_pkg.
`default_nettype none

module substr_cell (
    input  wire                   i_clk,
    input  wire substr_pkg::t_cell_ctl i_ctl,
    input  wire             [7:0] i_byte,
    input  wire             [7:0] i_needle_byte,
    input  wire                   i_active,
    output logic            [7:0] o_byte,
    output logic                  o_hit
);
    import substr_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Compare against the byte this cell will hold after the shift
    assign o_hit = !i_active ||
                   (fold_byte(i_byte, i_ctl.ignore_case) ==
                    fold_byte(i_needle_byte, i_ctl.ignore_case));

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    // payload only: stale bytes are never compared (count gates the match)
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ===== design/substr_out.sv =====
// Output stage: result register plus one skid entry, so the input side
// sees a registered stall. Depends on substr_pkg.
`default_nettype none

module substr_out (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_load,
    input  wire substr_pkg::t_result i_result,
    output logic                     o_full,
    output logic                     o_valid,
    output substr_pkg::t_result      o_result,
    input  wire                      i_stall
);
    import substr_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        priority if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_valid || take) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else begin
            if (take) begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== design/substring_search.sv =====
// Substring search top level: configuration registers, byte counter,
// row of window cells and the output stage. Depends on substr_pkg,
// substr_cell and substr_out.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_hay_byte, i_byte_present,
//                                                 i_end_of_haystack
//  result    out        o_valid / i_stall         o_found, o_match_index
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is taken every cycle unless stalled. Each byte shifts into a
// row of MAX_NEEDLE cells and all cells compare in that same cycle; the
// AND over the row and the count compare decide the match. The item ending
// the haystack loads the output stage. Reset (synchronous) clears the
// registers, counter and match flag; no clearing pass is needed. o_stall
// rises only when both the result register and its skid entry are full.
`default_nettype none

module substring_search #(
    parameter int unsigned MAX_NEEDLE   = 32,
    parameter int unsigned MAX_HAYSTACK = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // haystack items
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_hay_byte,
    input  wire         i_byte_present,
    input  wire         i_end_of_haystack,
    // result items
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_found,
    output logic [15:0] o_match_index,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);
    import substr_pkg::*;

    localparam int unsigned CW = $clog2(MAX_HAYSTACK + 1);
    localparam int unsigned IW = (CW > 16) ? CW : 16;
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_HAYSTACK);
    localparam logic [6:0]    MAXN     = 7'(MAX_NEEDLE);
    localparam logic [6:0]    STORE_N  = 7'(NEEDLE_STORE);

    // ---------------- configuration registers ----------------
    logic [5:0]  r_needle_length;
    logic        r_ignore_case;
    logic [63:0] r_needle_word [0:3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_length  <= '0;
            r_ignore_case    <= 1'b0;
            r_needle_word[0] <= '0;
            r_needle_word[1] <= '0;
            r_needle_word[2] <= '0;
            r_needle_word[3] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NEEDLE_LENGTH: r_needle_length  <= i_cfg_data[5:0];
                REG_IGNORE_CASE:   r_ignore_case    <= i_cfg_data[0];
                REG_NEEDLE_WORD0:  r_needle_word[0] <= i_cfg_data;
                REG_NEEDLE_WORD1:  r_needle_word[1] <= i_cfg_data;
                REG_NEEDLE_WORD2:  r_needle_word[2] <= i_cfg_data;
                REG_NEEDLE_WORD3:  r_needle_word[3] <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Needle as a byte array, byte 0 first
    logic [7:0] needle [0:NEEDLE_STORE-1];
    for (genvar j = 0; j < NEEDLE_STORE; j++) begin : g_needle
        assign needle[j] = r_needle_word[j / 8][(j % 8) * 8 +: 8];
    end

    // ---------------- item acceptance ----------------
    logic take_in;
    logic out_full;

    assign o_stall = out_full;
    assign take_in = i_valid && !out_full;

    // ---------------- per-haystack state ----------------
    logic [CW-1:0] r_bytes_seen, n_bytes_seen;
    logic          r_match_seen, n_match_seen;
    logic [15:0]   r_first_index, n_first_index;

    logic          shift;
    logic [CW-1:0] cnt_next;
    logic          len_ok;
    logic          len_zero;
    logic          all_hit;
    logic          hit_now;
    logic [IW-1:0] start_ext;
    logic          result_load;
    t_result       result_in;
    t_result       result_out;
    t_cell_ctl     cell_ctl;

    // bytes past the haystack limit are ignored entirely
    assign shift    = take_in && i_byte_present && (r_bytes_seen < CNT_MAX);
    assign cnt_next = r_bytes_seen + CW'(1);
    assign len_zero = (r_needle_length == 6'd0);
    assign len_ok   = ({1'b0, r_needle_length} <= MAXN) &&
                      ({1'b0, r_needle_length} <= STORE_N);

    assign cell_ctl.shift       = shift;
    assign cell_ctl.ignore_case = r_ignore_case;

    // ---------------- row of window cells ----------------
    logic [7:0] win  [0:MAX_NEEDLE-1];
    logic       hits [0:MAX_NEEDLE-1];
    logic [MAX_NEEDLE-1:0] hit_vec;

    for (genvar p = 0; p < MAX_NEEDLE; p++) begin : g_cell
        logic [7:0] byte_in;
        logic [5:0] nidx;
        logic       active;

        if (p == 0) begin : g_head
            assign byte_in = i_hay_byte;
        end else begin : g_body
            assign byte_in = win[p-1];
        end

        // window entry p lines up with needle byte len-1-p
        assign nidx   = r_needle_length - 6'(p + 1);
        assign active = ({1'b0, r_needle_length} > 7'(p));

        substr_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_byte       (byte_in),
            .i_needle_byte(needle[nidx[4:0]]),
            .i_active     (active),
            .o_byte       (win[p]),
            .o_hit        (hits[p])
        );

        assign hit_vec[p] = hits[p];
    end

    assign all_hit = &hit_vec;

    // first occurrence only; empty needle hits on the first byte
    assign hit_now = shift && !r_match_seen && len_ok &&
                     (len_zero ||
                      ((IW'(cnt_next) >= IW'(r_needle_length)) && all_hit));
    assign start_ext = IW'(cnt_next) - IW'(r_needle_length);

    always_comb begin
        n_bytes_seen  = r_bytes_seen;
        n_match_seen  = r_match_seen;
        n_first_index = r_first_index;
        if (shift) begin
            n_bytes_seen = cnt_next;
        end
        if (hit_now) begin
            n_match_seen  = 1'b1;
            n_first_index = len_zero ? 16'd0 : start_ext[15:0];
        end
        result_load           = take_in && i_end_of_haystack;
        result_in.found       = n_match_seen;
        result_in.match_index = n_match_seen ? n_first_index : 16'd0;
        if (result_load) begin
            n_bytes_seen = '0;
            n_match_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_match_seen <= 1'b0;
        end else begin
            r_bytes_seen <= n_bytes_seen;
            r_match_seen <= n_match_seen;
        end
        r_first_index <= n_first_index;
    end

    // ---------------- output stage ----------------
    substr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (result_load),
        .i_result(result_in),
        .o_full  (out_full),
        .o_valid (o_valid),
        .o_result(result_out),
        .i_stall (i_stall)
    );

    assign o_found       = result_out.found;
    assign o_match_index = result_out.match_index;

    // ---------------- assertions ----------------
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_index_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_match_index == 16'd0))
        else $error("non-zero index on a not-found result");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_end_of_haystack) |=> o_valid)
        else $error("end of haystack produced no result");

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_end_of_haystack) |=>
            ((r_bytes_seen == '0) && !r_match_seen))
        else $error("haystack state not cleared after result");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for substring_search: streams haystacks, predicts the
// first-match result of each one and checks every result item.
// Depends on substr_pkg (register indexes, result type) and the substring_search RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import substr_pkg::*;

    // Block sizing used for the instance and for the prediction
    localparam int unsigned NEEDLE_SLOTS = 32;
    localparam int unsigned HAY_LIMIT    = 65536;

    // Indexes with no register behind them; writes there must change nothing
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int SETTLE_CYCLES  = 4;
    // Watchdog limit in ns, set as a multiple of the 12 ns clock period
    localparam longint TIMEOUT_NS = 64'd1_500_000 * 12;

    // One haystack item as it goes onto the input channel
    typedef struct packed {
        logic [7:0] hay;
        logic       present;
        logic       last;
    } t_hay_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_hay_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_haystack = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_found;
    logic [15:0] o_match_index;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [63:0] i_cfg_data = 64'd0;

    substring_search #(
        .MAX_NEEDLE   (NEEDLE_SLOTS),
        .MAX_HAYSTACK (HAY_LIMIT)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_hay_byte        (i_hay_byte),
        .i_byte_present    (i_byte_present),
        .i_end_of_haystack (i_end_of_haystack),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_found           (o_found),
        .o_match_index     (o_match_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor state: own copy of the registers and the per-haystack state
    // ------------------------------------------------------------------
    logic [5:0]  needle_len_m = 6'd0;
    logic        case_fold_m = 1'b0;
    logic [63:0] needle_words_m [4] = '{default: 64'd0};

    logic [7:0]  recent_bytes [NEEDLE_SLOTS] = '{default: 8'h00};  // entry 0 newest
    int unsigned seen_count = 0;
    logic        match_seen = 1'b0;
    logic [15:0] first_index = 16'd0;

    t_result     expected_matches [$];
    t_hay_item   haystack_items [$];

    // Bookkeeping
    int items_queued = 0;
    int items_accepted = 0;
    int random_items = 0;
    int haystacks_queued = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int mismatches = 0;

    // Idling controls, set per phase by the stimulus
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;

    function automatic logic [7:0] needle_at(input int unsigned j);
        return needle_words_m[(j >> 3) & 3][(j & 7) * 8 +: 8];
    endfunction

    // Upper-case a..z only when case folding is on
    function automatic logic [7:0] caseless(input logic [7:0] b);
        if (case_fold_m && b >= 8'h61 && b <= 8'h7A) begin
            return b - 8'h20;
        end
        return b;
    endfunction

    // Advance the prediction by one accepted item; queue a result on the last one
    function automatic void search_step(input t_hay_item it);
        int unsigned nlen;
        int          k;
        bit          hit;
        t_result     res;
        nlen = needle_len_m;
        // bytes past the haystack limit are dropped entirely
        if (it.present && seen_count < HAY_LIMIT) begin
            for (k = NEEDLE_SLOTS - 1; k > 0; k--) begin
                recent_bytes[k] = recent_bytes[k-1];
            end
            recent_bytes[0] = it.hay;
            seen_count++;
            // needle longer than the storage never matches
            if (!match_seen && nlen <= NEEDLE_SLOTS && nlen <= NEEDLE_STORE) begin
                if (nlen == 0) begin
                    match_seen  = 1'b1;
                    first_index = 16'd0;
                end else if (seen_count >= nlen) begin
                    // window must hold a full needle; zero fill does not count
                    hit = 1'b1;
                    for (k = 0; k < nlen; k++) begin
                        if (caseless(recent_bytes[nlen-1-k]) != caseless(needle_at(k))) begin
                            hit = 1'b0;
                        end
                    end
                    if (hit) begin
                        match_seen  = 1'b1;
                        first_index = 16'(seen_count - nlen);
                    end
                end
            end
        end
        if (it.last) begin
            res.found       = match_seen;
            res.match_index = match_seen ? first_index : 16'd0;
            expected_matches.push_back(res);
            recent_bytes = '{default: 8'h00};
            seen_count   = 0;
            match_seen   = 1'b0;
            first_index  = 16'd0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one item in flight, held until accepted
    // ------------------------------------------------------------------
    t_hay_item drv_item;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                search_step(drv_item);
                items_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (haystack_items.size() != 0) begin
                    drv_item = haystack_items.pop_front();
                    i_hay_byte        <= drv_item.hay;
                    i_byte_present    <= drv_item.present;
                    i_end_of_haystack <= drv_item.last;
                    i_valid           <= 1'b1;
                    gap_left = gaps_on ? idle_length() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------
    int      stall_left = 0;
    t_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch("unexpected result", o_match_index, 16'd0);
                end else begin
                    want_res = expected_matches.pop_front();
                    results_checked++;
                    if (o_found !== want_res.found)
                        report_mismatch("found", 16'(o_found), 16'(want_res.found));
                    if (o_match_index !== want_res.match_index)
                        report_mismatch("match_index", o_match_index, want_res.match_index);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                stall_left = idle_length();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [7:0] b, input logic present, input logic last);
        t_hay_item it;
        it.hay     = b;
        it.present = present;
        it.last    = last;
        haystack_items.push_back(it);
        items_queued++;
        if (last) haystacks_queued++;
        if (present || last) random_items++;
    endtask

    // Register write; the block must be idle
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_NEEDLE_LENGTH: needle_len_m = val[5:0];
            REG_IGNORE_CASE:   case_fold_m = val[0];
            REG_NEEDLE_WORD0:  needle_words_m[0] = val;
            REG_NEEDLE_WORD1:  needle_words_m[1] = val;
            REG_NEEDLE_WORD2:  needle_words_m[2] = val;
            REG_NEEDLE_WORD3:  needle_words_m[3] = val;
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off until every queued item is taken and every result is back
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] b);
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) return b ^ 8'h20;
        return b;
    endfunction

    // Letters and the characters either side of the letter ranges
    function automatic logic [7:0] probe_char();
        case ($urandom_range(0, 9))
            0: return 8'h61;  // a
            1: return 8'h41;  // A
            2: return 8'h62;  // b
            3: return 8'h42;  // B
            4: return 8'h7A;  // z
            5: return 8'h5A;  // Z
            6: return 8'h60;  // just below a
            7: return 8'h40;  // just below A
            8: return 8'h7B;  // just above z
            default: return 8'h5B;  // just above Z
        endcase
    endfunction

    function automatic logic [7:0] hay_pick_byte();
        int unsigned nlen;
        int          r;
        logic [7:0]  b;
        nlen = needle_len_m;
        if (nlen > NEEDLE_SLOTS) nlen = NEEDLE_SLOTS;
        r = $urandom_range(0, 99);
        if (r < 25) return 8'($urandom_range(0, 255));
        if (r < 75 && nlen != 0) b = needle_at($urandom_range(0, nlen - 1));
        else b = probe_char();
        return ($urandom_range(0, 3) == 0) ? swap_case(b) : b;
    endfunction

    // Well-formed haystack with random content, usually holding a needle copy
    task automatic queue_random_haystack();
        logic [7:0]  hs [$];
        int unsigned nlen;
        int          n, pos, k, r;
        bit          sep_end;
        nlen = needle_len_m;
        r = $urandom_range(0, 99);
        n = (r < 5) ? 0 : (r < 90) ? $urandom_range(1, 24) : $urandom_range(25, 120);
        for (k = 0; k < n; k++) hs.push_back(hay_pick_byte());
        if (nlen >= 1 && nlen <= NEEDLE_SLOTS && n >= nlen && $urandom_range(0, 2) != 0) begin
            pos = $urandom_range(0, n - nlen);
            for (k = 0; k < nlen; k++)
                hs[pos+k] = ($urandom_range(0, 3) == 0) ? swap_case(needle_at(k)) : needle_at(k);
            // near miss on the needle's final byte
            if ($urandom_range(0, 3) == 0) hs[pos+nlen-1] = hs[pos+nlen-1] ^ 8'h01;
        end
        sep_end = ($urandom_range(0, 6) == 0);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(hs[k], 1'b1, (k == n - 1) && !sep_end);
        end
        // empty haystack, or end marked on an item without a byte
        if (n == 0 || sep_end) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // New needle and mode; phase 0 and 1 give the all-ones and all-zero needles
    task automatic configure_random(input int ph);
        int          r, w;
        int unsigned nlen;
        logic [63:0] word;
        r = $urandom_range(0, 99);
        if (ph < 2 || r < 12) nlen = NEEDLE_SLOTS;
        else if (r < 20) nlen = 0;
        else if (r < 27) nlen = $urandom_range(33, 63);
        else if (r < 75) nlen = $urandom_range(1, 6);
        else nlen = $urandom_range(7, 31);
        // junk above the register's own bits must be dropped
        write_reg(REG_NEEDLE_LENGTH, (rand64() & ~64'h3F) | 64'(nlen));
        write_reg(REG_IGNORE_CASE, rand64());
        for (w = 0; w < 4; w++) begin
            if (ph == 0) word = '1;
            else if (ph == 1) word = '0;
            else if ($urandom_range(0, 9) == 0) word = rand64();
            else for (int k = 0; k < 8; k++) word[k*8 +: 8] = probe_char();
            if (ph < 2 || $urandom_range(0, 3) != 0) begin
                case (w)
                    0: write_reg(REG_NEEDLE_WORD0, word);
                    1: write_reg(REG_NEEDLE_WORD1, word);
                    2: write_reg(REG_NEEDLE_WORD2, word);
                    default: write_reg(REG_NEEDLE_WORD3, word);
                endcase
            end
        end
        if ($urandom_range(0, 4) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand64());
    endtask

    // Haystack longer than the byte limit; needle 'QZQZQZ' at the given start,
    // and again later if extra_at is non-zero. Digits as filler never match.
    task automatic queue_long_haystack(input int start_at, input int extra_at, input int total);
        int k;
        logic [7:0] b;
        for (k = 0; k < total; k++) begin
            if (k >= start_at && k < start_at + 6) b = needle_at(k - start_at);
            else if (extra_at != 0 && k >= extra_at && k < extra_at + 6) b = needle_at(k - extra_at);
            else b = 8'h30 + 8'($urandom_range(0, 9));
            push_item(b, 1'b1, k == total - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_flow
        int ph, h, nh;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: empty needle, so any byte matches at 0
        push_item(8'h5A, 1'b0, 1'b1);         // empty haystack never matches
        push_item(8'h00, 1'b0, 1'b0);         // no byte, no end: ignored
        push_item(8'hFF, 1'b1, 1'b1);
        wait_idle();

        // Zero needle of three: a short haystack of zeros is not a match
        write_reg(REG_NEEDLE_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        wait_idle();

        // Case folding: letters only, the neighbours of the ranges stay apart
        write_reg(REG_IGNORE_CASE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_NEEDLE_WORD0, 64'h0000_0000_007A_6160);   // "`az"
        push_item(8'h40, 1'b1, 1'b0);
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'h60, 1'b1, 1'b0);
        push_item(8'h13, 1'b0, 1'b0);
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b1);
        // final byte is just above z; folding must not match it to the needle's z
        push_item(8'h60, 1'b1, 1'b0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h7B, 1'b1, 1'b1);
        wait_idle();

        // Needle lengths past the storage never match
        write_reg(REG_NEEDLE_LENGTH, 64'd33);
        push_item(8'h60, 1'b1, 1'b1);
        wait_idle();
        write_reg(REG_NEEDLE_LENGTH, 64'd63);
        push_item(8'h60, 1'b1, 1'b1);
        wait_idle();

        // Random phases: new settings, then a batch of haystacks with
        // per-phase choice of sender gaps and receiver stalls
        random_items = 0;
        ph = 0;
        while (random_items < RANDOM_ITEMS) begin
            configure_random(ph);
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            nh = $urandom_range(4, 12);
            for (h = 0; h < nh; h++) queue_random_haystack();
            wait_idle();
            ph++;
        end

        // Byte limit: a match ending on the last counted byte is found, one
        // straddling the limit or lying beyond it is not
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        write_reg(REG_NEEDLE_LENGTH, 64'd6);
        write_reg(REG_IGNORE_CASE, 64'd0);
        write_reg(REG_NEEDLE_WORD0, 64'h0000_5A51_5A51_5A51);
        queue_long_haystack(HAY_LIMIT - 6, 0, HAY_LIMIT + 4);
        queue_long_haystack(HAY_LIMIT - 3, HAY_LIMIT + 4, HAY_LIMIT + 14);
        // state must be clear again after an overlong haystack
        push_item(8'h51, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'h51, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'h51, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b1);
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d haystacks in %0d items over %0d random phases, %0d register writes",
                 haystacks_queued, items_queued, ph, reg_writes);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_matches.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", expected_matches.size());
        $display("status: fail");
        $finish;
    end

endmodule
